// ===== sv/tes_pkg.sv =====
`timescale 1ns / 1ps
package tes_pkg;
  localparam int TimersDefault = 16;
  localparam int TimeW = 48;
  localparam int IntervalW = 32;
  localparam int IdW = 31;
  localparam int TagW = 16;
  localparam int ReqW = 2;
  localparam int KindW = 3;

  localparam logic [ReqW-1:0] REQ_ADD = 2'd0;
  localparam logic [ReqW-1:0] REQ_CANCEL = 2'd1;
  localparam logic [ReqW-1:0] REQ_TICK = 2'd2;

  localparam logic [KindW-1:0] KIND_ADDED = 3'd0;
  localparam logic [KindW-1:0] KIND_FULL = 3'd1;
  localparam logic [KindW-1:0] KIND_CANCELLED = 3'd2;
  localparam logic [KindW-1:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [KindW-1:0] KIND_FIRED = 3'd4;

  typedef struct packed {
    logic [ReqW-1:0] req_type;
    logic [TimeW-1:0] time_ms;
    logic [IntervalW-1:0] interval_ms;
    logic periodic;
    logic [TagW-1:0] tag;
    logic [IdW-1:0] cancel_id;
  } req_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdW-1:0] timer_id;
    logic [TagW-1:0] fired_tag;
    logic last;
  } res_t;
endpackage

// ===== sv/tes_req_if.sv =====
`timescale 1ns / 1ps
interface tes_req_if;
  logic valid;
  logic ready;
  tes_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/tes_res_if.sv =====
`timescale 1ns / 1ps
interface tes_res_if;
  logic valid;
  logic ready;
  tes_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/tes_front.sv =====
`timescale 1ns / 1ps
// Input stage: drop unknown requests, queue the rest (two entries).
module tes_front (
  input  logic clk,
  input  logic rst,
  tes_req_if.sink req,
  output logic q_valid,
  input  logic q_pop,
  output tes_pkg::req_t q_data
);
  tes_pkg::req_t mem [2];
  logic wp;
  logic rp;
  logic [1:0] count;
  logic push;
  logic known;

  assign known = (req.data.req_type == tes_pkg::REQ_ADD) ||
                 (req.data.req_type == tes_pkg::REQ_CANCEL) ||
                 (req.data.req_type == tes_pkg::REQ_TICK);
  assign req.ready = (count != 2'd2);
  assign push = req.valid && req.ready && known;
  assign q_valid = (count != 2'd0);
  assign q_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= req.data;
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ===== sv/tes_back.sv =====
`timescale 1ns / 1ps
// Execution engine: one slot per cycle over the store for each scan.
module tes_back #(
  parameter int TIMERS = tes_pkg::TimersDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_pop,
  input  tes_pkg::req_t q_data,
  tes_res_if.source res,
  output logic close,
  input  logic closed
);
  localparam int SW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CW = $clog2(TIMERS + 1);
  localparam int FireMax = 16;
  localparam int FW = 5;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_EMIT, ST_CLOSE
  } state_t;

  state_t state;
  logic [TIMERS-1:0] slot_valid;
  logic [TIMERS-1:0] done;
  logic [tes_pkg::IdW-1:0] slot_id [TIMERS];
  logic [tes_pkg::TimeW-1:0] slot_expiry [TIMERS];
  logic [tes_pkg::IntervalW-1:0] slot_interval [TIMERS];
  logic [TIMERS-1:0] slot_periodic;
  logic [tes_pkg::TagW-1:0] slot_tag [TIMERS];
  logic [tes_pkg::IdW-1:0] id_counter;

  tes_pkg::req_t cur;
  logic [CW-1:0] idx;
  logic [SW-1:0] sidx;
  logic found;
  logic [SW-1:0] best;
  logic [tes_pkg::TimeW-1:0] best_exp;
  logic [tes_pkg::IdW-1:0] best_id;
  logic [FW-1:0] fired;
  logic [tes_pkg::TimeW:0] rearm;
  logic better;
  logic [tes_pkg::IdW-1:0] nid;
  logic emit;

  assign sidx = idx[SW-1:0];
  assign q_pop = (state == ST_IDLE) && q_valid;
  assign better = slot_valid[sidx] && !done[sidx] &&
                  (slot_expiry[sidx] <= cur.time_ms) &&
                  (!found || (slot_expiry[sidx] < best_exp) ||
                   ((slot_expiry[sidx] == best_exp) && (slot_id[sidx] < best_id)));
  assign rearm = {1'b0, cur.time_ms} +
                 {{(tes_pkg::TimeW + 1 - tes_pkg::IntervalW){1'b0}}, slot_interval[best]};
  assign nid = ((id_counter + 1'b1) == '0) ? {{(tes_pkg::IdW-1){1'b0}}, 1'b1}
                                           : id_counter + 1'b1;
  // A tick that found nothing more issues no transfer.
  assign emit = (state == ST_EMIT) && (!res.valid || res.ready) &&
                ((cur.req_type != tes_pkg::REQ_TICK) || found);
  // Close the tick only once its final fired result has left this register.
  assign close = (state == ST_CLOSE) && !res.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slot_valid <= '0;
      id_counter <= '0;
      res.valid <= 1'b0;
    end else begin
      res.valid <= emit || (res.valid && !res.ready);
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur <= q_data;
            idx <= '0;
            found <= 1'b0;
            done <= '0;
            fired <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Walk the slots; add seeks the lowest free, cancel the lowest match.
          if (cur.req_type == tes_pkg::REQ_ADD) begin
            if (!found && !slot_valid[sidx]) begin
              found <= 1'b1;
              best <= sidx;
            end
          end else if (cur.req_type == tes_pkg::REQ_CANCEL) begin
            if (!found && slot_valid[sidx] && slot_id[sidx] == cur.cancel_id) begin
              found <= 1'b1;
              best <= sidx;
            end
          end else if (better) begin
            found <= 1'b1;
            best <= sidx;
            best_exp <= slot_expiry[sidx];
            best_id <= slot_id[sidx];
          end
          if (idx == CW'(TIMERS - 1)) state <= ST_EMIT;
          idx <= idx + 1'b1;
        end
        ST_EMIT: begin
          if (!res.valid || res.ready) begin
            case (cur.req_type)
              tes_pkg::REQ_ADD: begin
                state <= ST_IDLE;
                res.data.fired_tag <= '0;
                res.data.last <= 1'b1;
                if (found) begin
                  id_counter <= nid;
                  slot_valid[best] <= 1'b1;
                  slot_id[best] <= nid;
                  slot_expiry[best] <= cur.time_ms;
                  slot_interval[best] <= cur.interval_ms;
                  slot_periodic[best] <= cur.periodic;
                  slot_tag[best] <= cur.tag;
                  res.data.kind <= tes_pkg::KIND_ADDED;
                  res.data.timer_id <= nid;
                end else begin
                  res.data.kind <= tes_pkg::KIND_FULL;
                  res.data.timer_id <= '0;
                end
              end
              tes_pkg::REQ_CANCEL: begin
                state <= ST_IDLE;
                res.data.fired_tag <= '0;
                res.data.last <= 1'b1;
                res.data.timer_id <= cur.cancel_id;
                if (found) begin
                  slot_valid[best] <= 1'b0;
                  res.data.kind <= tes_pkg::KIND_CANCELLED;
                end else begin
                  res.data.kind <= tes_pkg::KIND_NOT_FOUND;
                end
              end
              default: begin
                // Tick: fire the chosen slot, then rescan if more may follow.
                if (found) begin
                  res.data.kind <= tes_pkg::KIND_FIRED;
                  res.data.timer_id <= best_id;
                  res.data.fired_tag <= slot_tag[best];
                  res.data.last <= 1'b0;
                  done[best] <= 1'b1;
                  fired <= fired + 1'b1;
                  if (slot_periodic[best]) begin
                    slot_expiry[best] <= rearm[tes_pkg::TimeW] ? '1 :
                                         rearm[tes_pkg::TimeW-1:0];
                  end else begin
                    slot_valid[best] <= 1'b0;
                  end
                  if (fired == FW'(FireMax - 1)) begin
                    state <= ST_CLOSE;
                  end else begin
                    idx <= '0;
                    found <= 1'b0;
                    state <= ST_SCAN;
                  end
                end else if (fired != '0) begin
                  // Nothing more to fire: have the output stage mark the last transfer.
                  state <= ST_CLOSE;
                end else begin
                  state <= ST_IDLE;
                end
              end
            endcase
          end
        end
        ST_CLOSE: begin
          if (closed) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/tes_out.sv =====
`timescale 1ns / 1ps
// Output hold stage: hold back each fired transfer so a closing tick can set last.
module tes_out (
  input  logic clk,
  input  logic rst,
  tes_res_if.sink in,
  input  logic close,
  output logic closed,
  tes_res_if.source out
);
  logic held;
  tes_pkg::res_t hold;
  logic move;
  logic take;
  logic out_valid_next;

  assign move = !out.valid || out.ready;
  assign in.ready = move;
  assign take = in.valid && move;
  assign closed = close && move;
  assign out_valid_next = (out.valid && !out.ready) ||
                          (take && (in.data.last || held)) ||
                          (!take && closed && held);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      out.valid <= 1'b0;
    end else begin
      out.valid <= out_valid_next;
      if (take) begin
        if (in.data.last) begin
          out.data <= in.data;
        end else begin
          // release the one held before, keep this one back
          if (held) out.data <= hold;
          hold <= in.data;
          held <= 1'b1;
        end
      end else if (closed && held) begin
        out.data <= {hold.kind, hold.timer_id, hold.fired_tag, 1'b1};
        held <= 1'b0;
      end
    end
  end
endmodule

// ===== sv/timer_expiry_scheduler.sv =====
`timescale 1ns / 1ps
// Timer store of TIMERS slots. Add, cancel and tick requests enter on req and
// are queued two deep; results leave on res, the final one of each request
// flagged by last. Each add or cancel leaves the queue, scans all TIMERS slots
// and emits one result. A tick repeats the scan for every timer it fires (up
// to 16); a tick firing nothing gives no result. Results pass two register
// stages; the second holds each fired result back until the next one or the
// end of the tick is known. Unknown request codes are dropped without a
// result.
module timer_expiry_scheduler #(
  parameter int TIMERS = tes_pkg::TimersDefault
) (
  input  logic clk,
  input  logic rst,
  tes_req_if.sink req,
  tes_res_if.source res
);
  logic q_valid;
  logic q_pop;
  tes_pkg::req_t q_data;
  logic close;
  logic closed;

  tes_res_if mid ();

  tes_front u_front (
    .clk(clk), .rst(rst), .req(req),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  tes_back #(.TIMERS(TIMERS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .res(mid), .close(close), .closed(closed)
  );

  // Hold fired results one deep, releasing the final one with last set.
  tes_out u_out (
    .clk(clk), .rst(rst), .in(mid),
    .close(close), .closed(closed), .out(res)
  );
endmodule
